// ===== sv/jlss_pkg.sv =====
// Shared types and constants for the Jacobi Laplace stencil solver.
package jlss_pkg;

    // Command codes carried by the mode field
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_READ = 2'd1;
    localparam logic [1:0] MODE_RUN  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_GRID_SIDE   = 2'd0;
    localparam logic [1:0] CFG_SWEEP_COUNT = 2'd1;

    // Reset values of the configuration registers
    localparam logic [8:0]  GRID_SIDE_RST   = 9'd256;
    localparam logic [15:0] SWEEP_COUNT_RST = 16'd3001;

    // Sweep sequencer states
    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SWEEP,
        SEQ_COPY,
        SEQ_DONE
    } seq_state_t;

    // Phase of the work on one cell
    typedef enum logic [2:0] {
        PH_NORTH,
        PH_SOUTH,
        PH_WEST,
        PH_EAST,
        PH_WRITE
    } phase_t;

    // Status from the sweep sequencer to the top level
    typedef struct packed {
        logic busy;
        logic done;
        logic bank;
    } seq_status_t;

endpackage

// ===== sv/jlss_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
module jlss_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         q
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        q <= mem[raddr];
    end

endmodule

// ===== sv/jlss_sweep.sv =====
// Sweep sequencer: walks the interior, sums four neighbors, writes the other bank.
module jlss_sweep #(
    parameter int IDX  = 8,
    parameter int CWID = 24
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       go,
    input  logic [8:0]                 side,
    input  logic [15:0]                count,
    input  logic [CWID-1:0]            q_cur,
    output jlss_pkg::seq_status_t      status,
    output logic [2*IDX-1:0]           rd_addr,
    output logic                       wr_en,
    output logic [2*IDX-1:0]           wr_addr,
    output logic [CWID-1:0]            wr_data
);

    jlss_pkg::seq_state_t state_reg, state_next;
    jlss_pkg::phase_t     phase_reg, phase_next;
    logic [IDX-1:0]       r_reg, r_next, c_reg, c_next;
    logic [15:0]          k_reg, k_next;
    logic                 bank_reg, bank_next;
    logic [CWID+1:0]      acc_reg, acc_next;
    logic [CWID+1:0]      sum;
    logic [IDX-1:0]       side_m2;
    logic                 row_end, col_end, last_sweep;

    assign side_m2    = IDX'(side - 9'd2);
    assign col_end    = (c_reg == side_m2);
    assign row_end    = (r_reg == side_m2);
    assign last_sweep = (k_reg == count - 16'd1);
    assign sum        = acc_reg + (CWID+2)'(q_cur);

    // Hold sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= jlss_pkg::SEQ_IDLE;
            phase_reg <= jlss_pkg::PH_NORTH;
            bank_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            bank_reg  <= bank_next;
        end
    end

    // Hold counters and accumulator
    always_ff @(posedge clk)
    begin
        r_reg   <= r_next;
        c_reg   <= c_next;
        k_reg   <= k_next;
        acc_reg <= acc_next;
    end

    // Advance through sweeps, then copy the interior back to the other bank
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        k_next     = k_reg;
        bank_next  = bank_reg;
        acc_next   = acc_reg;
        rd_addr    = {r_reg, c_reg};
        wr_en      = 1'b0;
        wr_addr    = {r_reg, c_reg};
        wr_data    = q_cur;
        status     = '{busy: (state_reg != jlss_pkg::SEQ_IDLE),
                       done: (state_reg == jlss_pkg::SEQ_DONE),
                       bank: bank_reg};
        unique case (state_reg)
            jlss_pkg::SEQ_IDLE:
            begin
                r_next     = IDX'(1);
                c_next     = IDX'(1);
                k_next     = 16'd0;
                phase_next = jlss_pkg::PH_NORTH;
                if (go)
                begin
                    if ((side < 9'd3) || (count == 16'd0))
                    begin
                        state_next = jlss_pkg::SEQ_DONE;
                    end
                    else
                    begin
                        state_next = jlss_pkg::SEQ_SWEEP;
                    end
                end
            end
            jlss_pkg::SEQ_SWEEP:
            begin
                unique case (phase_reg)
                    jlss_pkg::PH_NORTH:
                    begin
                        rd_addr    = {r_reg - IDX'(1), c_reg};
                        phase_next = jlss_pkg::PH_SOUTH;
                    end
                    jlss_pkg::PH_SOUTH:
                    begin
                        rd_addr    = {r_reg + IDX'(1), c_reg};
                        acc_next   = (CWID+2)'(q_cur);
                        phase_next = jlss_pkg::PH_WEST;
                    end
                    jlss_pkg::PH_WEST:
                    begin
                        rd_addr    = {r_reg, c_reg - IDX'(1)};
                        acc_next   = sum;
                        phase_next = jlss_pkg::PH_EAST;
                    end
                    jlss_pkg::PH_EAST:
                    begin
                        rd_addr    = {r_reg, c_reg + IDX'(1)};
                        acc_next   = sum;
                        phase_next = jlss_pkg::PH_WRITE;
                    end
                    jlss_pkg::PH_WRITE:
                    begin
                        wr_en      = 1'b1;
                        wr_data    = sum[CWID+1:2];
                        phase_next = jlss_pkg::PH_NORTH;
                        if (col_end)
                        begin
                            c_next = IDX'(1);
                            if (row_end)
                            begin
                                r_next    = IDX'(1);
                                bank_next = ~bank_reg;
                                k_next    = k_reg + 16'd1;
                                if (last_sweep)
                                begin
                                    state_next = jlss_pkg::SEQ_COPY;
                                end
                            end
                            else
                            begin
                                r_next = r_reg + IDX'(1);
                            end
                        end
                        else
                        begin
                            c_next = c_reg + IDX'(1);
                        end
                    end
                    default:
                    begin
                        phase_next = jlss_pkg::PH_NORTH;
                    end
                endcase
            end
            jlss_pkg::SEQ_COPY:
            begin
                // Read a cell in the north phase, write it in the south phase
                if (phase_reg == jlss_pkg::PH_NORTH)
                begin
                    phase_next = jlss_pkg::PH_SOUTH;
                end
                else
                begin
                    wr_en      = 1'b1;
                    phase_next = jlss_pkg::PH_NORTH;
                    if (col_end)
                    begin
                        c_next = IDX'(1);
                        if (row_end)
                        begin
                            state_next = jlss_pkg::SEQ_DONE;
                        end
                        else
                        begin
                            r_next = r_reg + IDX'(1);
                        end
                    end
                    else
                    begin
                        c_next = c_reg + IDX'(1);
                    end
                end
            end
            jlss_pkg::SEQ_DONE:
            begin
                state_next = jlss_pkg::SEQ_IDLE;
            end
            default:
            begin
                state_next = jlss_pkg::SEQ_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_wr_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == jlss_pkg::SEQ_SWEEP || state_reg == jlss_pkg::SEQ_COPY))
        else $error("sweep write outside a run");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        status.done |=> !status.done)
        else $error("done longer than one cycle");
    a_bank_stable_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == jlss_pkg::SEQ_IDLE) |=> $stable(bank_reg))
        else $error("bank changed while idle");
`endif

endmodule

// ===== sv/jacobi_laplace_stencil_solver_unit.sv =====
// Top level: command decode, configuration registers and two grid banks.
// Load, read and ignored commands strobe their result in the cycle after they are accepted.
// A run does the sweeps, reading each cell's four neighbors in turn on one RAM read port,
// then a copy pass and a done state; the result strobes next.
// The receiver cannot stall; results are presented for one cycle only.
// Reset clears control state and restores grid_side 256, sweep_count 3001.
module jacobi_laplace_stencil_solver_unit #(
    parameter int MAX_SIDE  = 256,
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [7:0]  row,
    input  logic [7:0]  col,
    input  logic [22:0] cell_value,
    output logic        result_valid,
    output logic [22:0] read_value,
    output logic        run_done,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int IDX  = $clog2(MAX_SIDE);
    localparam int AW   = 2 * IDX;
    localparam int CWID = 8 + FRAC_BITS;

    logic [8:0]            grid_side_reg;
    logic [15:0]           sweep_count_reg;
    logic [8:0]            side_eff;
    logic                  accept, in_side, go;
    logic [AW-1:0]         cmd_addr;
    logic [CWID-1:0]       load_data;
    logic                  valid_reg, rd_ok_reg, done_reg;
    jlss_pkg::seq_status_t status;
    logic [AW-1:0]         sw_rd_addr, sw_wr_addr;
    logic                  sw_we;
    logic [CWID-1:0]       sw_wr_data;
    logic                  we0, we1, load_we;
    logic [AW-1:0]         waddr0, waddr1, raddr0;
    logic [CWID-1:0]       wdata0, wdata1, q0, q1, q_cur;

    assign side_eff  = (32'(grid_side_reg) > MAX_SIDE) ? 9'(MAX_SIDE) : grid_side_reg;
    assign accept    = start && !busy;
    assign in_side   = (32'(row) < 32'(side_eff)) && (32'(col) < 32'(side_eff));
    assign cmd_addr  = {IDX'(row), IDX'(col)};
    assign load_data = CWID'(cell_value);
    assign go        = accept && (mode == jlss_pkg::MODE_RUN);
    assign load_we   = accept && (mode == jlss_pkg::MODE_LOAD) && in_side;
    assign busy      = status.busy;
    assign cfg_ready = 1'b1;

    // Take configuration transfers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_side_reg   <= jlss_pkg::GRID_SIDE_RST;
            sweep_count_reg <= jlss_pkg::SWEEP_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                jlss_pkg::CFG_GRID_SIDE:   grid_side_reg   <= cfg_data[8:0];
                jlss_pkg::CFG_SWEEP_COUNT: sweep_count_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Strobe one result per command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rd_ok_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= (accept && !go) || status.done;
            rd_ok_reg <= accept && (mode == jlss_pkg::MODE_READ) && in_side;
            done_reg  <= status.done;
        end
    end

    assign result_valid = valid_reg;
    assign read_value   = rd_ok_reg ? 23'(q0) : 23'd0;
    assign run_done     = done_reg;

    // Route loads to both banks, sweep writes to the bank not in use
    assign q_cur  = status.bank ? q1 : q0;
    assign we0    = load_we || (sw_we && status.bank);
    assign we1    = load_we || (sw_we && !status.bank);
    assign waddr0 = status.busy ? sw_wr_addr : cmd_addr;
    assign waddr1 = status.busy ? sw_wr_addr : cmd_addr;
    assign wdata0 = status.busy ? sw_wr_data : load_data;
    assign wdata1 = status.busy ? sw_wr_data : load_data;
    assign raddr0 = status.busy ? sw_rd_addr : cmd_addr;

    jlss_sweep #(
        .IDX  (IDX),
        .CWID (CWID)
    ) u_sweep (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go),
        .side    (side_eff),
        .count   (sweep_count_reg),
        .q_cur   (q_cur),
        .status  (status),
        .rd_addr (sw_rd_addr),
        .wr_en   (sw_we),
        .wr_addr (sw_wr_addr),
        .wr_data (sw_wr_data)
    );

    jlss_ram #(
        .WIDTH (CWID),
        .DEPTH (1 << AW)
    ) u_bank0 (
        .clk   (clk),
        .we    (we0),
        .waddr (waddr0),
        .wdata (wdata0),
        .raddr (raddr0),
        .q     (q0)
    );

    jlss_ram #(
        .WIDTH (CWID),
        .DEPTH (1 << AW)
    ) u_bank1 (
        .clk   (clk),
        .we    (we1),
        .waddr (waddr1),
        .wdata (wdata1),
        .raddr (sw_rd_addr),
        .q     (q1)
    );

`ifndef NO_ASSERTIONS
    a_done_has_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        run_done |-> (result_valid && !rd_ok_reg))
        else $error("run_done without its strobe");
    a_busy_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> busy)
        else $error("run accepted but sequencer idle");
    a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !load_we)
        else $error("load accepted during a run");
`endif

endmodule
